/* sv/lsd_radix_sort_base10_defines.svh */
// assertion macros shared by the radix sort block
`ifndef LSD_RADIX_SORT_BASE10_DEFINES_SVH
`define LSD_RADIX_SORT_BASE10_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lsd_rs_pkg.sv */
// constants, types and helper functions of the decimal radix sort
package lsd_rs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int RADIX     = 10;
    localparam int VAL_W     = 31;
    localparam int NDIG      = 10;
    localparam int DIG_W     = 4;
    localparam int BCD_W     = NDIG * DIG_W;
    localparam int WORD_W    = BCD_W + VAL_W;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int PASS_W    = $clog2(NDIG + 1);
    localparam int CONV_W    = $clog2(VAL_W);
    localparam int BKT_W     = $clog2(RADIX);

    typedef logic [NDIG-1:0][DIG_W-1:0] t_bcd;

    // one stored entry: decimal digits next to the binary value
    typedef struct packed {
        t_bcd             bcd;
        logic [VAL_W-1:0] val;
    } t_word;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_CONV   = 10'b00_0000_0010,
        S_STORE  = 10'b00_0000_0100,
        S_CLR    = 10'b00_0000_1000,
        S_COUNT  = 10'b00_0001_0000,
        S_PREFIX = 10'b00_0010_0000,
        S_SCAT   = 10'b00_0100_0000,
        S_OUT_RD = 10'b00_1000_0000,
        S_OUT_LD = 10'b01_0000_0000,
        S_SEND   = 10'b10_0000_0000
    } t_state;

    // add three to every digit of five or more before the next shift
    function automatic t_bcd dabble_fix(input t_bcd b);
        t_bcd r;
        for (int k = 0; k < NDIG; k++) begin
            r[k] = (b[k] >= DIG_W'(5)) ? DIG_W'(b[k] + DIG_W'(3)) : b[k];
        end
        return r;
    endfunction

    // number of significant decimal digits, zero for the value zero
    function automatic logic [PASS_W-1:0] num_digits(input t_bcd b);
        logic [PASS_W-1:0] r;
        r = '0;
        for (int k = 0; k < NDIG; k++) begin
            if (b[k] != '0) begin
                r = PASS_W'(k + 1);
            end
        end
        return r;
    endfunction

endpackage

/* sv/lsd_rs_in_if.sv */
// input channel: one value to sort per item
interface lsd_rs_in_if import lsd_rs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value_in;
    logic             last_in;

    modport source (output valid, output value_in, output last_in, input ready);
    modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

/* sv/lsd_rs_out_if.sv */
// output channel: one sorted value per item
interface lsd_rs_out_if import lsd_rs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sorted_value;
    logic             last_out;
    logic             dropped;

    modport source (output valid, output sorted_value, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input dropped,
                    output ready);
endinterface

/* sv/lsd_rs_ram.sv */
// generic simple dual-port ram with registered read data
module lsd_rs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/lsd_radix_sort_base10.sv */
// Decimal LSD radix sort of up to MAX_ITEMS non-negative 31-bit values. Items are taken
// one at a time; each accepted item passes through a shift-add-3 binary-to-decimal
// converter and is then written, with its digits, into the working buffer, and ready is
// low meanwhile, so a new item is taken only after the last one is stored. Items beyond
// capacity are dropped and flagged. The item marked last starts the sort: one counting
// pass per significant digit of the largest value, each pass a bucket clear, count walk,
// nine-step prefix sum and backward scatter walk over the two ping-pong buffers. Results
// then leave one at a time while the sink is ready; each is read and registered before
// it is offered, and the next is fetched only once the sink has taken it. No item is
// accepted from the start of the sort until the final result has been taken.
`include "lsd_radix_sort_base10_defines.svh"

module lsd_radix_sort_base10 import lsd_rs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsd_rs_in_if.sink     i_in,
    lsd_rs_out_if.source  o_out
);
    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [PASS_W-1:0]    r_max_dig;
    logic [PASS_W-1:0]    r_pass;
    logic                 r_sel;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_rd_vld;
    logic [CNT_W-1:0]     r_cnt [RADIX];
    logic [BKT_W-1:0]     r_pd;
    logic [CONV_W-1:0]    r_conv_cnt;
    logic [VAL_W-1:0]     r_bin;
    logic [VAL_W-1:0]     r_val;
    t_bcd                 r_bcd;
    logic                 r_last;
    logic                 r_o_valid;
    logic [VAL_W-1:0]     r_o_val;
    logic                 r_o_last;
    logic                 r_o_drop;

    t_bcd                 n_bcd;
    logic [VAL_W-1:0]     n_bin;
    logic [PASS_W-1:0]    n_dig;
    logic [WORD_W-1:0]    rdata_a;
    logic [WORD_W-1:0]    rdata_b;
    t_word                rd_word;
    logic [BKT_W-1:0]     rd_digit;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic                 wr_work;
    logic [ADDR_W-1:0]    wr_addr;
    t_word                wr_data;
    logic                 we_a;
    logic                 we_b;
    logic                 in_acc;
    logic                 out_acc;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // handshake and result ports
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.sorted_value = r_o_val;
    assign o_out.last_out     = r_o_last;
    assign o_out.dropped      = r_o_drop;

    // one shift-add-3 step of the decimal conversion
    always_comb begin
        t_bcd fixed;
        fixed = dabble_fix(r_bcd);
        n_bcd = t_bcd'({fixed[NDIG-1:0], r_bin[VAL_W-1]} & {BCD_W{1'b1}});
        n_bin = {r_bin[VAL_W-2:0], 1'b0};
        n_dig = num_digits(r_bcd);
    end

    // working buffer read side
    assign rd_word  = r_sel ? t_word'(rdata_b) : t_word'(rdata_a);
    assign rd_digit = BKT_W'(rd_word.bcd[r_pass]);

    always_comb begin
        if (r_state == S_SCAT) begin
            rd_addr = ADDR_W'(r_idx - CNT_W'(1));
        end else begin
            rd_addr = r_idx[ADDR_W-1:0];
        end
    end

    // writes: loads go to the working buffer, scatter goes to the other one
    always_comb begin
        wr_en   = 1'b0;
        wr_work = 1'b1;
        wr_addr = r_count[ADDR_W-1:0];
        wr_data = '{bcd: r_bcd, val: r_val};
        case (r_state)
            S_STORE: begin
                wr_en = 1'b1;
            end
            S_SCAT: begin
                wr_en   = r_rd_vld;
                wr_work = 1'b0;
                wr_addr = ADDR_W'(r_cnt[rd_digit] - CNT_W'(1));
                wr_data = rd_word;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign we_a = wr_en && (wr_work ? !r_sel : r_sel);
    assign we_b = wr_en && (wr_work ? r_sel : !r_sel);

    lsd_rs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata_a)
    );

    lsd_rs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata_b)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_max_dig <= '0;
            r_pass    <= '0;
            r_sel     <= 1'b0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
            r_pd      <= '0;
            for (int k = 0; k < RADIX; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            case (r_state)
                // take an item, drop it if the buffer is full
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_count < CNT_W'(MAX_ITEMS)) begin
                            r_bin      <= i_in.value_in;
                            r_val      <= i_in.value_in;
                            r_bcd      <= '0;
                            r_conv_cnt <= '0;
                            r_last     <= i_in.last_in;
                            r_state    <= S_CONV;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_in.last_in) begin
                                r_pass  <= '0;
                                r_state <= S_CLR;
                            end
                        end
                    end
                end
                // binary to decimal, one bit per cycle
                S_CONV: begin
                    r_bcd      <= n_bcd;
                    r_bin      <= n_bin;
                    r_conv_cnt <= r_conv_cnt + CONV_W'(1);
                    if (r_conv_cnt == CONV_W'(VAL_W - 1)) begin
                        r_state <= S_STORE;
                    end
                end
                // entry is written this cycle, track the widest value
                S_STORE: begin
                    r_count <= r_count + CNT_W'(1);
                    if (n_dig > r_max_dig) begin
                        r_max_dig <= n_dig;
                    end
                    if (r_last) begin
                        r_pass  <= '0;
                        r_state <= S_CLR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // start a digit pass, or emit once all digits are done
                S_CLR: begin
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    if (r_pass == r_max_dig) begin
                        r_state <= S_OUT_RD;
                    end else begin
                        for (int k = 0; k < RADIX; k++) begin
                            r_cnt[k] <= '0;
                        end
                        r_state <= S_COUNT;
                    end
                end
                // histogram of the current digit
                S_COUNT: begin
                    if (r_idx != r_count) begin
                        r_idx    <= r_idx + CNT_W'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_cnt[rd_digit] <= r_cnt[rd_digit] + CNT_W'(1);
                    end else if (r_idx == r_count) begin
                        r_pd    <= BKT_W'(1);
                        r_state <= S_PREFIX;
                    end
                end
                // running sum, one bucket per cycle
                S_PREFIX: begin
                    r_cnt[r_pd] <= r_cnt[r_pd] + r_cnt[r_pd - BKT_W'(1)];
                    r_pd        <= r_pd + BKT_W'(1);
                    if (r_pd == BKT_W'(RADIX - 1)) begin
                        r_idx    <= r_count;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_SCAT;
                    end
                end
                // backward walk, stable placement into the other buffer
                S_SCAT: begin
                    if (r_idx != '0) begin
                        r_idx    <= r_idx - CNT_W'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_cnt[rd_digit] <= r_cnt[rd_digit] - CNT_W'(1);
                    end else if (r_idx == '0) begin
                        r_sel   <= !r_sel;
                        r_pass  <= r_pass + PASS_W'(1);
                        r_state <= S_CLR;
                    end
                end
                // read address is presented this cycle
                S_OUT_RD: begin
                    r_state <= S_OUT_LD;
                end
                // load the output register
                S_OUT_LD: begin
                    r_o_val   <= rd_word.val;
                    r_o_last  <= (CNT_W'(r_idx + CNT_W'(1)) == r_count);
                    r_o_drop  <= r_ovf;
                    r_o_valid <= 1'b1;
                    r_state   <= S_SEND;
                end
                // hold the item until the sink takes it
                S_SEND: begin
                    if (out_acc) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_count   <= '0;
                            r_ovf     <= 1'b0;
                            r_max_dig <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `LSD_ASSERT_SAME(a_out_only_send, i_clk, i_rst_n, o_out.valid, r_state == S_SEND, "result valid outside send state")
    `LSD_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ITEMS), "item count beyond capacity")
    `LSD_ASSERT_SAME(a_scat_bucket, i_clk, i_rst_n, (r_state == S_SCAT) && r_rd_vld, r_cnt[rd_digit] != '0, "scatter from an empty bucket")
    `LSD_ASSERT_NEXT(a_set_cleared, i_clk, i_rst_n, out_acc && o_out.last_out, (r_count == '0) && (r_state == S_IDLE), "set not cleared after final result")
endmodule
